@@ hw/rtl/bero_pkg.sv @@
// shared constants and types for the 3x3 binary erosion block
`timescale 1ns / 1ps

package bero_pkg;

	localparam int PIX_W          = 8;
	localparam int CFG_W          = 11;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int RESET_WIDTH    = 1024;
	localparam int RESET_HEIGHT   = 1024;

	// register index as decoded from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// input beat kind
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// one line buffer entry: pixel from two rows up and from the row above
	typedef struct packed {
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] current;
	} line_entry_t;

	// per-beat control carried through the window stage
	typedef struct packed {
		logic due;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} win_ctl_t;

endpackage

@@ hw/rtl/bero_line_ram.sv @@
// single-port-write, single-port-read line buffer ram with registered read
`timescale 1ns / 1ps

module bero_line_ram #(
	parameter int DEPTH  = bero_pkg::DEF_MAX_WIDTH,
	parameter int DATA_W = 2 * bero_pkg::PIX_W,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/binary_erosion_3x3.sv @@
// top level of the streaming 3x3 binary erosion block
//
//  port group   dir  content
//  s_*          in   tdata[7:0] = pixel_in, tuser[0] = kind
//  m_*          out  tdata[7:0] = pixel_out, tlast = frame_last
//  apb          in   reg 0 image_width at 0x0, reg 1 image_height at 0x4
//
//  one beat per cycle sustained while m_tready is high; a result passes the line ram read
//  stage, then the output register, and leaves one row plus one pixel behind the input
//  reset clears the position counters and the window; line buffers hold nothing until written
//  m_tready low stalls the window stage, and s_tready drops once that stage is also full
`timescale 1ns / 1ps

module binary_erosion_3x3 #(
	parameter int MAX_WIDTH  = bero_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bero_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bero_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel_in
	input  logic                             s_tuser,   // [0] kind
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bero_pkg::PIX_W-1:0]       m_tdata,   // [7:0] pixel_out
	output logic                             m_tlast,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bero_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bero_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bero_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int OROW_W = $clog2(MAX_HEIGHT);
	localparam int PIX_W  = bero_pkg::PIX_W;
	localparam int CFG_W  = bero_pkg::CFG_W;
	localparam int RST_W  = (bero_pkg::RESET_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : bero_pkg::RESET_WIDTH;
	localparam int RST_H  = (bero_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
		MAX_HEIGHT : bero_pkg::RESET_HEIGHT;

	// configuration registers
	logic [CFG_W-1:0]  width_q, height_q;
	logic [COL_W-1:0]  w_m1_q;
	logic [ROW_W-1:0]  h_q;
	logic [OROW_W-1:0] h_m1_q;
	logic              cfg_wr;
	logic [31:0]       w_clamp, h_clamp;
	logic [CFG_W-1:0]  cfg_raw;

	// position counters
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [OROW_W-1:0] out_row_q;

	// accept stage
	logic              s_acc, take, flushing, due, last;
	logic [PIX_W-1:0]  pix_in;

	// window stage
	logic                  valid_s1;
	logic [PIX_W-1:0]      pix_s1;
	logic [COL_W-1:0]      addr_s1;
	bero_pkg::win_ctl_t    ctl_s1;
	logic                  byp_s1;
	bero_pkg::line_entry_t byp_data_s1;
	logic                  adv_s1;
	bero_pkg::line_entry_t ram_rd, line_rd, line_wr;

	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] win_n [9];
	logic             keep;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_last_q;

	// apb
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_raw = pwdata[CFG_W-1:0];
	assign prdata  = (paddr[2] == bero_pkg::REG_IMAGE_HEIGHT) ?
		{{(bero_pkg::APB_DATA_W-CFG_W){1'b0}}, height_q} :
		{{(bero_pkg::APB_DATA_W-CFG_W){1'b0}}, width_q};

	always_comb begin
		w_clamp = {{(32-CFG_W){1'b0}}, cfg_raw};
		if (cfg_raw == '0) begin
			w_clamp = 32'd1;
		end else if (w_clamp > 32'(MAX_WIDTH)) begin
			w_clamp = 32'(MAX_WIDTH);
		end
		h_clamp = {{(32-CFG_W){1'b0}}, cfg_raw};
		if (cfg_raw == '0) begin
			h_clamp = 32'd1;
		end else if (h_clamp > 32'(MAX_HEIGHT)) begin
			h_clamp = 32'(MAX_HEIGHT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(bero_pkg::RESET_WIDTH);
			height_q <= CFG_W'(bero_pkg::RESET_HEIGHT);
			w_m1_q   <= COL_W'(RST_W - 1);
			h_q      <= ROW_W'(RST_H);
			h_m1_q   <= OROW_W'(RST_H - 1);
		end else if (cfg_wr) begin
			case (paddr[2])
				bero_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_raw;
					w_m1_q  <= COL_W'(w_clamp - 32'd1);
				end
				bero_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_raw;
					h_q      <= ROW_W'(h_clamp);
					h_m1_q   <= OROW_W'(h_clamp - 32'd1);
				end
				default: begin
				end
			endcase
		end
	end

	// accept stage
	assign adv_s1   = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign s_acc    = s_tvalid && s_tready;
	assign flushing = in_row_q >= h_q;
	assign take     = s_acc && (flushing || s_tuser == bero_pkg::KIND_PIXEL);
	assign pix_in   = flushing ? '0 : s_tdata;
	assign due      = (in_row_q > ROW_W'(1)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
	assign last     = due && out_col_q == w_m1_q && out_row_q == h_m1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == w_m1_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (due) begin
					if (out_col_q == w_m1_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// window stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1         <= pix_in;
			addr_s1        <= in_col_q;
			ctl_s1.due     <= due;
			ctl_s1.top     <= out_row_q == '0;
			ctl_s1.bottom  <= out_row_q == h_m1_q;
			ctl_s1.left    <= out_col_q == '0;
			ctl_s1.right   <= out_col_q == w_m1_q;
			ctl_s1.last    <= last;
			byp_s1         <= valid_s1 && adv_s1 && addr_s1 == in_col_q;
			byp_data_s1    <= line_wr;
		end
	end

	bero_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * PIX_W),
		.ADDR_W (COL_W)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (in_col_q),
		.rd_data (ram_rd),
		.wr_en   (valid_s1 && adv_s1),
		.wr_addr (addr_s1),
		.wr_data (line_wr)
	);

	assign line_rd         = byp_s1 ? byp_data_s1 : ram_rd;
	assign line_wr.above   = line_rd.current;
	assign line_wr.current = pix_s1;

	// shifted window and neighbor test with edge replication
	always_comb begin
		int rr;
		int cc;
		for (int r = 0; r < 3; r++) begin
			win_n[r*3]   = win_q[r*3+1];
			win_n[r*3+1] = win_q[r*3+2];
		end
		win_n[2] = line_rd.above;
		win_n[5] = line_rd.current;
		win_n[8] = pix_s1;
		keep = 1'b1;
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				rr = dr;
				cc = dc;
				if (dr == 0 && ctl_s1.top) rr = 1;
				if (dr == 2 && ctl_s1.bottom) rr = 1;
				if (dc == 0 && ctl_s1.left) cc = 1;
				if (dc == 2 && ctl_s1.right) cc = 1;
				if (!(dr == 1 && dc == 1) && win_n[rr*3+cc] == '0) begin
					keep = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1 && adv_s1) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1 && ctl_s1.due;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && ctl_s1.due) begin
			out_pix_q  <= keep ? win_n[4] : '0;
			out_last_q <= ctl_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

endmodule
